// ===== rtl/hysteresis_period_meter_assert.svh =====
// Assertion macros for the hysteresis period meter.
`ifndef HYSTERESIS_PERIOD_METER_ASSERT_SVH
`define HYSTERESIS_PERIOD_METER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define HPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define HPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define HPM_ASSERT_NOW(label, ante, cons, msg)
`define HPM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/hpm_pkg.sv =====
// Shared types, widths, codes and defaults of the hysteresis period meter.
package hpm_pkg;

    localparam int SAMPLE_W   = 14;
    localparam int TS_W       = 32;
    localparam int FREQ_W     = 26;
    localparam int LEVEL_W    = 14;
    localparam int HDIV_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = 5;

    localparam int CLOCK_HZ_DEF    = 48000000;
    localparam int SAMPLE_BITS_DEF = 14;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_DIV  = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX_RST = 14'd16383;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN_RST = 14'd0;
    localparam logic [HDIV_W-1:0]  HYST_DIV_RST  = 8'd10;

    // divider operand selection
    localparam logic [1:0] DSEL_MAX  = 2'd0;
    localparam logic [1:0] DSEL_MIN  = 2'd1;
    localparam logic [1:0] DSEL_FREQ = 2'd2;

    typedef struct packed {
        logic       accept;      // input transfer this cycle
        logic       div_start;
        logic [1:0] div_sel;
        logic       load_upper;
        logic       load_lower;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic result_hit;        // current item closes a valid measurement
        logic phase_rise2;       // waiting for second rise
        logic div_done;
    } t_status;

endpackage

// ===== rtl/hpm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module hpm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hpm_pkg::DIV_W-1:0] i_dividend,
    input  logic [hpm_pkg::DIV_W-1:0] i_divisor,
    output logic [hpm_pkg::DIV_W-1:0] o_quotient,
    output logic                      o_done
);

    logic [hpm_pkg::DIV_W-1:0]     r_rem, r_quo, r_den;
    logic [hpm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy, r_done;
    logic [hpm_pkg::DIV_W:0]       w_shift, w_diff;

    assign w_shift = {r_rem, r_quo[hpm_pkg::DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {hpm_pkg::DIV_CNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[hpm_pkg::DIV_W]) begin
                r_rem <= w_diff[hpm_pkg::DIV_W-1:0];
                r_quo <= {r_quo[hpm_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[hpm_pkg::DIV_W-1:0];
                r_quo <= {r_quo[hpm_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/hpm_dp.sv =====
// Datapath: registers, thresholds, edge detection, period and frequency.
module hpm_dp #(
    parameter int CLOCK_HZ    = hpm_pkg::CLOCK_HZ_DEF,
    parameter int SAMPLE_BITS = hpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [hpm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [hpm_pkg::TS_W-1:0]       i_timestamp,
    input  hpm_pkg::t_cmd                  i_cmd,
    output hpm_pkg::t_status               o_status,
    output logic [hpm_pkg::TS_W-1:0]       o_period_ticks,
    output logic [hpm_pkg::FREQ_W-1:0]     o_frequency_hz
);

    localparam int SB = (SAMPLE_BITS < hpm_pkg::SAMPLE_W) ? SAMPLE_BITS : hpm_pkg::SAMPLE_W;
    localparam logic [hpm_pkg::SAMPLE_W-1:0] SMASK = hpm_pkg::SAMPLE_W'((1 << SB) - 1);
    localparam logic [hpm_pkg::DIV_W-1:0]    CLK_CONST = hpm_pkg::DIV_W'(CLOCK_HZ);

    localparam logic [1:0] PH_RISE1 = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_RISE2 = 2'd2;

    logic [hpm_pkg::LEVEL_W-1:0] r_level_max, r_level_min;
    logic [hpm_pkg::HDIV_W-1:0]  r_hyst_div;
    logic [hpm_pkg::LEVEL_W-1:0] r_upper;
    logic [hpm_pkg::LEVEL_W:0]   r_lower;
    logic [1:0]                  r_phase, n_phase;
    logic [hpm_pkg::TS_W-1:0]    r_first, r_period;
    logic [hpm_pkg::TS_W-1:0]    r_out_period;
    logic [hpm_pkg::FREQ_W-1:0]  r_out_freq;

    logic [hpm_pkg::SAMPLE_W-1:0] w_s;
    logic                         w_above, w_below, w_capture;
    logic [hpm_pkg::TS_W-1:0]     w_period;
    logic [hpm_pkg::DIV_W-1:0]    w_dividend, w_divisor, w_quo, w_fraw;
    logic [hpm_pkg::LEVEL_W-1:0]  w_margin;
    logic [hpm_pkg::FREQ_W-1:0]   w_freq;
    logic                         w_div_done;

    assign w_s      = i_sample & SMASK;
    assign w_above  = w_s > r_upper;
    assign w_below  = {1'b0, w_s} < r_lower;
    assign w_period = r_first - i_timestamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_max <= hpm_pkg::LEVEL_MAX_RST;
            r_level_min <= hpm_pkg::LEVEL_MIN_RST;
            r_hyst_div  <= hpm_pkg::HYST_DIV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hpm_pkg::REG_LEVEL_MAX: r_level_max <= i_cfg_data;
                hpm_pkg::REG_LEVEL_MIN: r_level_min <= i_cfg_data;
                hpm_pkg::REG_HYST_DIV:  r_hyst_div  <= i_cfg_data[hpm_pkg::HDIV_W-1:0];
                default: ;
            endcase
        end
    end

    // phase tracking
    always_comb begin
        n_phase   = r_phase;
        w_capture = 1'b0;
        unique case (r_phase)
            PH_FALL:  if (w_below) n_phase = PH_RISE2;
            PH_RISE2: if (w_above) n_phase = PH_RISE1;
            default: begin
                n_phase   = w_above ? PH_FALL : PH_RISE1;
                w_capture = w_above;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RISE1;
            r_first <= '0;
        end else if (i_cmd.accept) begin
            r_phase <= n_phase;
            if (w_capture) r_first <= i_timestamp;
        end
    end

    assign o_status.result_hit  = (r_phase == PH_RISE2) && w_above && (r_first >= i_timestamp);
    assign o_status.phase_rise2 = (r_phase == PH_RISE2);
    assign o_status.div_done    = w_div_done;

    // shared divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            hpm_pkg::DSEL_MAX: begin
                w_dividend = hpm_pkg::DIV_W'(r_level_max);
                w_divisor  = hpm_pkg::DIV_W'(r_hyst_div);
            end
            hpm_pkg::DSEL_MIN: begin
                w_dividend = hpm_pkg::DIV_W'(r_level_min);
                w_divisor  = hpm_pkg::DIV_W'(r_hyst_div);
            end
            default: begin
                w_dividend = CLK_CONST;
                w_divisor  = w_period;
            end
        endcase
    end

    hpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // zero divisor means zero margin; quotient never exceeds the level
    assign w_margin = (r_hyst_div == '0) ? '0 : w_quo[hpm_pkg::LEVEL_W-1:0];

    // zero period saturates to the clock rate, then floor at 1 and clamp
    assign w_fraw = (r_period == '0) ? CLK_CONST : w_quo;
    always_comb begin
        if (w_fraw == '0)
            w_freq = hpm_pkg::FREQ_W'(1);
        else if (w_fraw > hpm_pkg::DIV_W'(hpm_pkg::FREQ_MAX))
            w_freq = hpm_pkg::FREQ_MAX;
        else
            w_freq = w_fraw[hpm_pkg::FREQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_upper) r_upper <= r_level_max - w_margin;
        if (i_cmd.load_lower) r_lower <= {1'b0, r_level_min} + {1'b0, w_margin};
        if (i_cmd.accept && o_status.result_hit) r_period <= w_period;
        if (i_cmd.load_out) begin
            r_out_period <= r_period;
            r_out_freq   <= w_freq;
        end
    end

    assign o_period_ticks = r_out_period;
    assign o_frequency_hz = r_out_freq;

endmodule

// ===== rtl/hpm_ctrl.sv =====
// Controller: threshold refresh, item acceptance, frequency divide, output valid.
module hpm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  hpm_pkg::t_status i_status,
    output hpm_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MAX_GO   = 3'd1;
    localparam logic [2:0] S_MAX_RUN  = 3'd2;
    localparam logic [2:0] S_MIN_GO   = 3'd3;
    localparam logic [2:0] S_MIN_RUN  = 3'd4;
    localparam logic [2:0] S_FREQ_RUN = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid;
    logic       w_ready, w_xfer;

    // a second-rise item may produce a result, so it waits for an empty output
    assign w_ready = (r_state == S_IDLE) && !i_cfg_we &&
                     (!r_out_valid || !i_status.phase_rise2);
    assign w_xfer  = w_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = hpm_pkg::DSEL_FREQ;
        unique case (r_state)
            S_MAX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hpm_pkg::DSEL_MAX;
                n_state         = S_MAX_RUN;
            end
            S_MAX_RUN: if (i_status.div_done) begin
                o_cmd.load_upper = 1'b1;
                n_state          = S_MIN_GO;
            end
            S_MIN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = hpm_pkg::DSEL_MIN;
                n_state         = S_MIN_RUN;
            end
            S_MIN_RUN: if (i_status.div_done) begin
                o_cmd.load_lower = 1'b1;
                n_state          = S_IDLE;
            end
            S_FREQ_RUN: if (i_status.div_done) begin
                o_cmd.load_out = 1'b1;
                n_state        = S_IDLE;
            end
            default: if (w_xfer) begin
                o_cmd.accept = 1'b1;
                if (i_status.result_hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_FREQ_RUN;
                end
            end
        endcase
        if (i_cfg_we) n_state = S_MAX_GO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_MAX_GO;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = w_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/hysteresis_period_meter.sv =====
// Top level of the hysteresis period meter.
// Reciprocal period meter with hysteresis. Each accepted sample is compared
// against an upper threshold (level_max - level_max/hysteresis_divisor) and a
// lower threshold (level_min + level_min/hysteresis_divisor). A rise above the
// upper threshold captures the down-counting timestamp, a fall below the lower
// threshold arms the detector, and the next rise closes the measurement. If the
// timer wrapped in between (first capture below the second) nothing is emitted
// and the search restarts; otherwise one result transfer carries period_ticks
// (first minus second capture) and frequency_hz = CLOCK_HZ / period, floored
// at 1, CLOCK_HZ for a zero period, clamped to 26 bits. Flow: a sample that
// closes no measurement leaves the controller idle, so the next one can follow
// right after. A closing sample is accepted, runs through the shared restoring
// divider one quotient bit per cycle and loads the output register; no further
// sample is taken meanwhile. A finished result waits in the output register
// while further samples are taken; only a sample in the second-rise phase waits
// for that register to drain. After reset and after every configuration write
// the thresholds are recomputed on the same divider (two divides) and no sample
// is taken meanwhile; configuration writes are taken at any time and restart it.
// Bits of sample above SAMPLE_BITS are ignored.
`include "hysteresis_period_meter_assert.svh"

module hysteresis_period_meter #(
    parameter int CLOCK_HZ    = hpm_pkg::CLOCK_HZ_DEF,
    parameter int SAMPLE_BITS = hpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [hpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [hpm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [hpm_pkg::TS_W-1:0]       i_timestamp,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [hpm_pkg::TS_W-1:0]       o_period_ticks,
    output logic [hpm_pkg::FREQ_W-1:0]     o_frequency_hz
);

    hpm_pkg::t_cmd    w_cmd;
    hpm_pkg::t_status w_status;

    // sequencing: threshold refresh, accept, frequency divide, output valid
    hpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // registers, compare logic, shared divider, result registers
    hpm_dp #(
        .CLOCK_HZ    (CLOCK_HZ),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_timestamp    (i_timestamp),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_period_ticks (o_period_ticks),
        .o_frequency_hz (o_frequency_hz)
    );

    // a closing sample is only taken with the output register empty
    `HPM_ASSERT_NOW(a_hit_needs_room, w_cmd.accept && w_status.result_hit, !o_out_valid, "result transfer would overwrite pending output")
    // a closing sample blocks further transfers while the divider runs
    `HPM_ASSERT_NEXT(a_hit_blocks, w_cmd.accept && w_status.result_hit, !o_in_ready, "sample taken during frequency divide")
    // a sample transfer never coincides with a configuration write
    `HPM_ASSERT_NOW(a_no_cfg_xfer, i_in_valid && o_in_ready, !i_cfg_we, "sample transfer during configuration write")
    // a fresh result always carries a nonzero frequency
    `HPM_ASSERT_NOW(a_freq_nonzero, $rose(o_out_valid), o_frequency_hz != '0, "zero frequency in result")

endmodule

// ===== tb/hysteresis_period_meter_checker.sv =====
// Scoreboard for the hysteresis period meter: mirrors registers, predicts and compares results.
module hysteresis_period_meter_checker #(
    parameter int CLOCK_HZ    = hpm_pkg::CLOCK_HZ_DEF,
    parameter int SAMPLE_BITS = hpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [hpm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [hpm_pkg::TS_W-1:0]       i_timestamp,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [hpm_pkg::TS_W-1:0]       i_period_ticks,
    input  logic [hpm_pkg::FREQ_W-1:0]     i_frequency_hz,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = hpm_pkg::SAMPLE_W;
    localparam int TS_W     = hpm_pkg::TS_W;
    localparam int FREQ_W   = hpm_pkg::FREQ_W;
    localparam int LEVEL_W  = hpm_pkg::LEVEL_W;
    localparam int HDIV_W   = hpm_pkg::HDIV_W;

    localparam logic [1:0] SEEK_RISE  = 2'd0;
    localparam logic [1:0] SEEK_FALL  = 2'd1;
    localparam logic [1:0] SEEK_RISE2 = 2'd2;

    typedef struct packed {
        logic [TS_W-1:0]   period;
        logic [FREQ_W-1:0] freq;
    } t_meas;

    logic [LEVEL_W-1:0] lvl_max;
    logic [LEVEL_W-1:0] lvl_min;
    logic [HDIV_W-1:0]  hyst_div;
    logic [1:0]         seek;
    logic [TS_W-1:0]    first_ts;
    t_meas              meas_q[$];
    int                 fails = 0;
    int                 pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    // divisor zero means no margin
    function automatic logic [31:0] margin_for(input logic [LEVEL_W-1:0] lvl);
        if (hyst_div == '0) return 32'd0;
        return 32'(lvl) / 32'(hyst_div);
    endfunction

    function automatic logic [FREQ_W-1:0] freq_for(input logic [TS_W-1:0] period);
        logic [31:0] q;
        q = (period == '0) ? 32'(CLOCK_HZ) : 32'(CLOCK_HZ) / period;
        if (q == 32'd0) q = 32'd1;
        if (q > 32'(hpm_pkg::FREQ_MAX)) q = 32'(hpm_pkg::FREQ_MAX);
        return q[FREQ_W-1:0];
    endfunction

    // one detector step; returns 1 when a measurement closes with a result
    function automatic bit advance_detector(input logic [SAMPLE_W-1:0] smp,
                                            input logic [TS_W-1:0] ts,
                                            output t_meas res);
        logic [31:0] s;
        logic [31:0] upper;
        logic [31:0] lower;
        bit          hit;
        s     = 32'(smp) & ((32'd1 << SAMPLE_BITS) - 32'd1);
        upper = 32'(lvl_max) - margin_for(lvl_max);
        lower = 32'(lvl_min) + margin_for(lvl_min);
        hit   = 1'b0;
        res   = '0;
        case (seek)
            SEEK_FALL: begin
                if (s < lower) seek = SEEK_RISE2;
            end
            SEEK_RISE2: begin
                if (s > upper) begin
                    seek = SEEK_RISE;
                    // timer wrapped between the captures: drop it
                    if (first_ts >= ts) begin
                        res.period = first_ts - ts;
                        res.freq   = freq_for(res.period);
                        hit        = 1'b1;
                    end
                end
            end
            default: begin
                seek = SEEK_RISE;
                if (s > upper) begin
                    first_ts = ts;
                    seek     = SEEK_FALL;
                end
            end
        endcase
        return hit;
    endfunction

    always @(posedge i_clk) begin : p_track
        t_meas want;
        t_meas got;
        if (!i_rst_n) begin
            lvl_max  = hpm_pkg::LEVEL_MAX_RST;
            lvl_min  = hpm_pkg::LEVEL_MIN_RST;
            hyst_div = hpm_pkg::HYST_DIV_RST;
            seek     = SEEK_RISE;
            first_ts = '0;
            meas_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (meas_q.size() == 0) begin
                    $display("%0t: expected no result, actual period_ticks %0d frequency_hz %0d",
                             $time, i_period_ticks, i_frequency_hz);
                    fails++;
                end else begin
                    want = meas_q.pop_front();
                    if (i_period_ticks !== want.period) begin
                        $display("%0t: period_ticks expected %0d actual %0d",
                                 $time, want.period, i_period_ticks);
                        fails++;
                    end
                    if (i_frequency_hz !== want.freq) begin
                        $display("%0t: frequency_hz expected %0d actual %0d",
                                 $time, want.freq, i_frequency_hz);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (advance_detector(i_sample, i_timestamp, got)) meas_q.push_back(got);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hpm_pkg::REG_LEVEL_MAX: lvl_max  = i_cfg_data[LEVEL_W-1:0];
                    hpm_pkg::REG_LEVEL_MIN: lvl_min  = i_cfg_data[LEVEL_W-1:0];
                    hpm_pkg::REG_HYST_DIV:  hyst_div = i_cfg_data[HDIV_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = meas_q.size();
    end

endmodule

// ===== tb/hysteresis_period_meter_tb.sv =====
// Testbench top for the hysteresis period meter: clock, reset, stimulus and verdict.
module hysteresis_period_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = hpm_pkg::SAMPLE_W;
    localparam int TS_W       = hpm_pkg::TS_W;
    localparam int FREQ_W     = hpm_pkg::FREQ_W;
    localparam int LEVEL_W    = hpm_pkg::LEVEL_W;
    localparam int HDIV_W     = hpm_pkg::HDIV_W;
    localparam int CFG_IDX_W  = hpm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = hpm_pkg::CFG_DATA_W;

    localparam int CLOCK_HZ        = hpm_pkg::CLOCK_HZ_DEF;
    localparam int CLK_HIGH        = 4;
    localparam int CLK_LOW         = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int IDLE_PCT        = 34;     // idle chance per cycle, both sides
    localparam int ITEM_TARGET     = 750;
    localparam int N_PHASES        = 9;
    localparam int HOLD_OFF_CYCLES = 400;    // long receiver stall
    localparam int SETTLE_CYCLES   = 40;     // settle time for a closing sample
    localparam int QUIET_LIMIT     = 4000;   // cycles without any transfer
    localparam int SAMPLE_TOP      = (1 << SAMPLE_W) - 1;
    localparam logic [TS_W-1:0]      TS_TOP    = '1;
    // index 3 is not a register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_sample;
    logic [TS_W-1:0]       i_timestamp;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [TS_W-1:0]       o_period_ticks;
    logic [FREQ_W-1:0]     o_frequency_hz;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int items_sent   = 0;
    bit steady       = 1'b0;   // no idling on either side while set
    bit stall_req    = 1'b0;   // asks the receiver for one long hold-off

    // stimulus-side view of the thresholds, used only to shape samples
    logic [31:0] upper_thr;
    logic [31:0] lower_thr;

    hysteresis_period_meter #(
        .CLOCK_HZ    (CLOCK_HZ),
        .SAMPLE_BITS (hpm_pkg::SAMPLE_BITS_DEF)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_timestamp    (i_timestamp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_period_ticks (o_period_ticks),
        .o_frequency_hz (o_frequency_hz)
    );

    hysteresis_period_meter_checker #(
        .CLOCK_HZ    (CLOCK_HZ),
        .SAMPLE_BITS (hpm_pkg::SAMPLE_BITS_DEF)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_timestamp    (i_timestamp),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_period_ticks (o_period_ticks),
        .i_frequency_hz (o_frequency_hz),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        i_clk = 1'b0;
        #CLK_LOW;
        i_clk = 1'b1;
        #CLK_HIGH;
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random backpressure, a steady window, and on request one long
    // hold-off so the output register fills and the input channel stalls.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                stall_req = 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // One sample transfer. Inputs move on the falling edge; acceptance is
    // seen at the rising edge. Valid drops only for the random gap before
    // an item, never while an item is on offer.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [TS_W-1:0] ts);
        @(negedge i_clk);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_sample    <= smp;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Wait until every expected result has gone out, then let any
    // measurement that closes without a result (wrapped timer) finish.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Writes all three registers plus the unused index. Bits of the divisor
    // write above its width are random and must be dropped.
    task automatic apply_config(input logic [LEVEL_W-1:0] mx, input logic [LEVEL_W-1:0] mn,
                                input logic [HDIV_W-1:0] dv);
        logic [CFG_DATA_W-1:0] dword;
        dword = CFG_DATA_W'($urandom());
        dword[HDIV_W-1:0] = dv;
        drain();
        write_reg(hpm_pkg::REG_LEVEL_MAX, mx);
        write_reg(hpm_pkg::REG_LEVEL_MIN, mn);
        write_reg(hpm_pkg::REG_HYST_DIV, dword);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
        upper_thr = 32'(mx) - ((dv == '0) ? 32'd0 : 32'(mx) / 32'(dv));
        lower_thr = 32'(mn) + ((dv == '0) ? 32'd0 : 32'(mn) / 32'(dv));
    endtask

    // Sample above the upper threshold; full scale when none exists.
    function automatic logic [SAMPLE_W-1:0] above_upper();
        if (upper_thr >= SAMPLE_TOP) return SAMPLE_W'(SAMPLE_TOP);
        return SAMPLE_W'($urandom_range(SAMPLE_TOP, upper_thr + 1));
    endfunction

    // Sample below the lower threshold; zero when none exists.
    function automatic logic [SAMPLE_W-1:0] below_lower();
        if (lower_thr == 0) return '0;
        if (lower_thr > SAMPLE_TOP) return SAMPLE_W'($urandom());
        return SAMPLE_W'($urandom_range(lower_thr - 1, 0));
    endfunction

    // A few in-band samples that neither rise nor fall, when the band exists.
    task automatic send_in_band(input int n);
        if (lower_thr <= upper_thr) begin
            repeat (n) send_sample(SAMPLE_W'($urandom_range(upper_thr, lower_thr)), $urandom());
        end
    endtask

    // Well-formed rise / fall / rise with the two capture timestamps given.
    task automatic measure(input logic [TS_W-1:0] ts_first, input logic [TS_W-1:0] ts_second,
                           input int n_band);
        send_sample(above_upper(), ts_first);
        send_in_band(n_band);
        send_sample(below_lower(), $urandom());
        send_in_band(n_band);
        send_sample(above_upper(), ts_second);
    endtask

    // Picks capture pairs across the interesting period ranges.
    task automatic random_measure();
        logic [TS_W-1:0] t1;
        logic [TS_W-1:0] t2;
        int unsigned     pick;
        t1   = $urandom();
        pick = $urandom_range(9);
        case (pick)
            0: t2 = t1;                                              // zero period
            1: t2 = t1 - $urandom_range(100, 1);                     // top frequencies
            2: t2 = t1 - (CLOCK_HZ - 1 + $urandom_range(2));          // around 1 Hz
            3: t2 = $urandom();                                      // anything
            4: begin                                                 // wrapped timer
                t1 = $urandom_range(32'hFFFF_0000);
                t2 = t1 + 1 + $urandom_range(65534);
            end
            5: begin                                                 // widest period
                t1 = TS_TOP;
                t2 = '0;
            end
            default: t2 = t1 - $urandom_range(1 << 20, 1);
        endcase
        measure(t1, t2, $urandom_range(2));
    endtask

    initial begin
        int seq_no;
        int phase_end;
        int pick;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_timestamp = '0;
        seq_no      = 0;
        upper_thr   = 32'(hpm_pkg::LEVEL_MAX_RST)
                      - 32'(hpm_pkg::LEVEL_MAX_RST) / 32'(hpm_pkg::HYST_DIV_RST);
        lower_thr   = 32'(hpm_pkg::LEVEL_MIN_RST)
                      + 32'(hpm_pkg::LEVEL_MIN_RST) / 32'(hpm_pkg::HYST_DIV_RST);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // Reset levels: rise at full scale; lower threshold is zero so no
        // sample can fall below it.
        send_sample(SAMPLE_W'(SAMPLE_TOP), TS_TOP);
        send_sample('0, '0);
        // Upper 10800, lower 3300; detector is still waiting for the fall.
        apply_config(14'd12000, 14'd3000, 8'd10);
        send_sample(14'd3300, $urandom());           // at lower: not a fall
        send_sample(14'd3299, $urandom());           // fall
        send_sample(14'd10800, '0);                  // at upper: not a rise
        send_sample(SAMPLE_W'(SAMPLE_TOP), '0);      // all-ones period, frequency floors at 1
        measure(32'd5000, 32'd5000, 0);              // zero period saturates
        measure(32'd7, 32'd6, 0);                    // period of one tick
        measure(TS_TOP, TS_TOP - CLOCK_HZ, 0);       // exactly 1 Hz
        measure(TS_TOP, TS_TOP - CLOCK_HZ - 1, 0);   // quotient zero
        measure(32'd100, 32'd101, 1);                // wrapped timer, no result
        send_sample('0, '0);                         // low while waiting for a rise

        // ---- random part, one register setting per phase ----
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: apply_config(14'd12000, 14'd3000, 8'd10);
                1: apply_config(14'h3FFF, 14'h3FFF, 8'd1);     // lower above upper
                2: apply_config(14'd16000, 14'd500, 8'd0);     // divisor zero
                3: apply_config(14'h3FFF, 14'd1, 8'hFF);
                4: apply_config(14'd0, 14'h3FFF, 8'd2);        // upper is zero
                5: apply_config(14'd9000, 14'd0, 8'd3);        // nothing can fall
                default: begin
                    pick = $urandom_range(SAMPLE_TOP, 2000);
                    apply_config(LEVEL_W'(pick), LEVEL_W'($urandom_range(pick / 2)),
                                 HDIV_W'($urandom_range(255)));
                end
            endcase
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (N_PHASES - ph);
            // setting with no fall possible gets a short run
            if (ph == 5) phase_end = items_sent + 30;
            while (items_sent < phase_end) begin
                seq_no++;
                if (seq_no == 15 || seq_no == 130) stall_req = 1'b1;
                steady = (seq_no >= 60 && seq_no < 100);
                pick   = $urandom_range(99);
                if (pick < 80) begin
                    random_measure();
                end else if (pick < 90) begin
                    repeat ($urandom_range(4, 1)) send_sample(SAMPLE_W'($urandom()), $urandom());
                end else begin
                    // broken sequence: double rise, fall, no closing rise
                    send_sample(above_upper(), $urandom());
                    send_sample(above_upper(), $urandom());
                    send_sample(below_lower(), $urandom());
                end
            end
        end
        steady = 1'b0;

        drain();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
